// File: rtl/mcpd_pkg.sv
package mcpd_pkg;

  // Field and register widths.
  localparam int WHEELS         = 4;
  localparam int WHEEL_W        = 2;
  localparam int STICK_W        = 11;
  localparam int MEAS_W         = 16;
  localparam int GAIN_W         = 16;
  localparam int LIM_W          = 15;
  localparam int OUT_W          = 16;
  localparam int GAIN_FRAC_BITS = 12;

  // Stream widths.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_KP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_KI   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SPEED   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd6;

  // Shared multiplier geometry.
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 19;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Mixing and division by the full stick deflection.
  localparam int MIX_W      = 13;
  localparam int MAG_W      = 27;
  localparam int DIV_SHIFT  = 27;
  localparam int Q0_W       = 18;
  localparam int Q_W        = 19;
  localparam int STICK_FULL = 660;
  localparam logic [MUL_B_W-1:0] STICK_FULL_B = MUL_B_W'(STICK_FULL);
  localparam logic [MUL_B_W-1:0] RECIP_B = MUL_B_W'((64'd1 << DIV_SHIFT) / STICK_FULL);

  // PI arithmetic.
  localparam int SINT_W = 24;
  localparam int CINT_W = 27;
  localparam int SUM_W  = 35;
  localparam int SH_W   = SUM_W - GAIN_FRAC_BITS;
  localparam int SPEED_INT_LIMIT   = 1000;
  localparam int CURRENT_INT_LIMIT = 8000;
  localparam logic signed [SUM_W-1:0] SINT_MAX =
    SUM_W'(SPEED_INT_LIMIT) <<< GAIN_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] CINT_MAX =
    SUM_W'(CURRENT_INT_LIMIT) <<< GAIN_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] TRUNC_BIAS =
    (SUM_W'(1) <<< GAIN_FRAC_BITS) - SUM_W'(1);

  typedef struct packed {
    logic        [WHEEL_W-1:0] wheel;
    logic signed [STICK_W-1:0] stick_turn;
    logic signed [STICK_W-1:0] stick_strafe;
    logic signed [STICK_W-1:0] stick_forward;
    logic signed [MEAS_W-1:0]  measured_speed;
    logic signed [MEAS_W-1:0]  measured_current;
  } item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] speed_kp;
    logic [GAIN_W-1:0] speed_ki;
    logic [GAIN_W-1:0] current_kp;
    logic [GAIN_W-1:0] current_ki;
    logic [LIM_W-1:0]  full_speed;
    logic [LIM_W-1:0]  target_limit;
    logic [LIM_W-1:0]  drive_limit;
  } cfg_t;

  typedef struct packed {
    logic        [WHEEL_W-1:0] wheel_out;
    logic signed [OUT_W-1:0]   current_target;
    logic signed [OUT_W-1:0]   drive_value;
  } res_t;

endpackage

// File: rtl/mecanum_cascaded_pi_drive.sv
// Channel  Direction  Handshake               Payload
// in_      slave      in_tvalid / in_tready   tuser wheel; tdata sticks and measurements
// out_     master     out_tvalid / out_tready tuser wheel; tdata current target and drive
// cfg_     slave      cfg_valid / cfg_ready   cfg_index register, cfg_data value
//
// The sequencer works on one beat at a time from accept until its result is offered; the shared
// multiplier forms seven products in sequence.
// The input is not ready again until the result has moved to the output register,
// so a new beat cannot be accepted while the previous one is still in the sequencer.
// Reset (rst_n low, synchronous) restores the register defaults and clears all integrators.
// A stalled output holds its beat while the next input beat may already be accepted.
module mecanum_cascaded_pi_drive (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [10:0] stick_turn, [21:11] stick_strafe, [32:22] stick_forward,
  // [48:33] measured_speed, [64:49] measured_current, [71:65] unused
  input  logic [mcpd_pkg::IN_DATA_W-1:0]        in_tdata,
  // [1:0] wheel
  input  logic [mcpd_pkg::WHEEL_W-1:0]          in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [15:0] current_target, [31:16] drive_value
  output logic [mcpd_pkg::OUT_DATA_W-1:0]       out_tdata,
  // [1:0] wheel_out
  output logic [mcpd_pkg::WHEEL_W-1:0]          out_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mcpd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mcpd_pkg::GAIN_W-1:0]           cfg_data
);
  import mcpd_pkg::*;

  cfg_t                    cfg_r, cfg_nxt;
  item_t                   item;
  res_t                    res;
  logic                    core_idle, res_valid, res_take, in_fire;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic [WHEEL_W-1:0]      out_user_r;
  logic signed [OUT_W-1:0] lim_ct, lim_dv;
  logic                    ct_ok, dv_ok;

  // Unpack the input beat.
  assign item.wheel            = in_tuser;
  assign item.stick_turn       = $signed(in_tdata[10:0]);
  assign item.stick_strafe     = $signed(in_tdata[21:11]);
  assign item.stick_forward    = $signed(in_tdata[32:22]);
  assign item.measured_speed   = $signed(in_tdata[48:33]);
  assign item.measured_current = $signed(in_tdata[64:49]);

  assign in_tready = core_idle;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration register writes; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPEED_KP:     cfg_nxt.speed_kp     = cfg_data;
        REG_SPEED_KI:     cfg_nxt.speed_ki     = cfg_data;
        REG_CURRENT_KP:   cfg_nxt.current_kp   = cfg_data;
        REG_CURRENT_KI:   cfg_nxt.current_ki   = cfg_data;
        REG_FULL_SPEED:   cfg_nxt.full_speed   = cfg_data[LIM_W-1:0];
        REG_TARGET_LIMIT: cfg_nxt.target_limit = cfg_data[LIM_W-1:0];
        REG_DRIVE_LIMIT:  cfg_nxt.drive_limit  = cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_kp     <= GAIN_W'(8192);
      cfg_r.speed_ki     <= GAIN_W'(143);
      cfg_r.current_kp   <= GAIN_W'(7373);
      cfg_r.current_ki   <= GAIN_W'(82);
      cfg_r.full_speed   <= LIM_W'(5000);
      cfg_r.target_limit <= LIM_W'(5000);
      cfg_r.drive_limit  <= LIM_W'(16000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mcpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire),
    .item      (item),
    .cfg       (cfg_r),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register between the sequencer and the result channel.
  assign res_take      = res_valid && (!out_valid_r || out_tready);
  assign out_valid_nxt = res_take || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= {res.drive_value, res.current_target};
      out_user_r <= res.wheel_out;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Limits seen by the result when it is handed over.
  assign lim_ct = $signed(OUT_W'(cfg_r.target_limit));
  assign lim_dv = $signed(OUT_W'(cfg_r.drive_limit));
  assign ct_ok  = (res.current_target <= lim_ct) && (res.current_target >= -lim_ct);
  assign dv_ok  = (res.drive_value <= lim_dv) && (res.drive_value >= -lim_dv);

  a_ct_limit: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> ct_ok)
    else $error("current target outside its limit");

  a_dv_limit: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> dv_ok)
    else $error("drive value outside its limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input ready right after an accepted beat");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !out_tvalid |=> !out_tvalid)
    else $error("result appeared one cycle after accept");

endmodule

// File: rtl/mcpd_mul.sv
module mcpd_mul (
  input  logic                                 clk,
  input  logic signed [mcpd_pkg::MUL_A_W-1:0]  a,
  input  logic signed [mcpd_pkg::MUL_B_W-1:0]  b,
  output logic signed [mcpd_pkg::MUL_P_W-1:0]  p
);
  import mcpd_pkg::*;

  logic signed [MUL_P_W-1:0] p_r;

  // One signed product per cycle, registered.
  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign p = p_r;

endmodule

// File: rtl/mcpd_core.sv
module mcpd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  mcpd_pkg::item_t item,
  input  mcpd_pkg::cfg_t  cfg,
  output logic            idle,
  output logic            res_valid,
  input  logic            res_take,
  output mcpd_pkg::res_t  res
);
  import mcpd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MIX  = 3'd1;
  localparam logic [2:0] ST_MAG  = 3'd2;
  localparam logic [2:0] ST_Q0   = 3'd3;
  localparam logic [2:0] ST_FIX  = 3'd4;
  localparam logic [2:0] ST_ERR  = 3'd5;
  localparam logic [2:0] ST_INT  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32767);
    lo = -SUM_W'(32768);
    if (v > hi) begin
      sat16 = OUT_W'(hi);
    end else if (v < lo) begin
      sat16 = OUT_W'(lo);
    end else begin
      sat16 = v[OUT_W-1:0];
    end
  endfunction

  logic [2:0]                state_r, state_nxt;
  logic                      inner_r, inner_nxt;
  item_t                     item_r, item_nxt;
  logic signed [MIX_W-1:0]   mix_r, mix_nxt;
  logic [MAG_W-1:0]          m_r, m_nxt;
  logic                      neg_r, neg_nxt;
  logic [Q_W-1:0]            q_r, q_nxt;
  logic signed [OUT_W-1:0]   err_r, err_nxt;
  logic signed [OUT_W-1:0]   ctgt_r, ctgt_nxt;
  logic signed [SINT_W-1:0]  sint_r [WHEELS];
  logic signed [SINT_W-1:0]  sint_nxt [WHEELS];
  logic signed [CINT_W-1:0]  cint_r [WHEELS];
  logic signed [CINT_W-1:0]  cint_nxt [WHEELS];

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic signed [MIX_W-1:0]   f_s, s_s, t_s, mix_start;
  logic [MAG_W:0]            prod_mag;
  logic [MAG_W-1:0]          rem;
  logic signed [Q_W:0]       q_signed;
  logic signed [OUT_W-1:0]   target;
  logic signed [SUM_W-1:0]   integ_old, ilim, isum, iclamp;
  logic signed [SUM_W-1:0]   acc, acc_adj;
  logic signed [SH_W-1:0]    acc_sh, lim_s, pi_out;
  logic [LIM_W-1:0]          lim_sel;
  logic [GAIN_W-1:0]         kp_sel;
  logic signed [OUT_W-1:0]   pi_out16;

  mcpd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Mecanum mix of the incoming sticks, taken at accept.
  always_comb begin
    f_s = MIX_W'(item.stick_forward);
    s_s = MIX_W'(item.stick_strafe);
    t_s = MIX_W'(item.stick_turn);
    case (item.wheel)
      2'd0:    mix_start =  f_s + s_s + t_s;
      2'd1:    mix_start =  f_s - s_s + t_s;
      2'd2:    mix_start = -f_s - s_s + t_s;
      default: mix_start = -f_s + s_s + t_s;
    endcase
  end

  // Loop selection: outer speed loop first, then inner current loop.
  assign kp_sel    = inner_r ? cfg.current_kp  : cfg.speed_kp;
  assign lim_sel   = inner_r ? cfg.drive_limit : cfg.target_limit;
  assign ilim      = inner_r ? CINT_MAX : SINT_MAX;
  assign integ_old = inner_r ? SUM_W'(cint_r[item_r.wheel]) : SUM_W'(sint_r[item_r.wheel]);

  // Integrator update and clamp.
  always_comb begin
    isum = integ_old + $signed(mul_p[SUM_W-1:0]);
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
  end

  // PI output: truncate toward zero, then clamp to the loop limit.
  always_comb begin
    acc     = $signed(mul_p[SUM_W-1:0]) + integ_old;
    acc_adj = acc[SUM_W-1] ? acc + TRUNC_BIAS : acc;
    acc_sh  = acc_adj[SUM_W-1:GAIN_FRAC_BITS];
    lim_s   = $signed(SH_W'(lim_sel));
    if (acc_sh > lim_s) begin
      pi_out = lim_s;
    end else if (acc_sh < -lim_s) begin
      pi_out = -lim_s;
    end else begin
      pi_out = acc_sh;
    end
    pi_out16 = pi_out[OUT_W-1:0];
  end

  // Signed speed target from the corrected quotient.
  assign prod_mag = mul_p[MUL_P_W-1] ? (MAG_W+1)'(-mul_p) : (MAG_W+1)'(mul_p);
  assign rem      = m_r - mul_p[MAG_W-1:0];
  assign q_signed = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign target   = sat16(SUM_W'(q_signed));

  // Sequencer and operand selection for the shared multiplier.
  always_comb begin
    state_nxt = state_r;
    inner_nxt = inner_r;
    item_nxt  = item_r;
    mix_nxt   = mix_r;
    m_nxt     = m_r;
    neg_nxt   = neg_r;
    q_nxt     = q_r;
    err_nxt   = err_r;
    ctgt_nxt  = ctgt_r;
    sint_nxt  = sint_r;
    cint_nxt  = cint_r;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt  = item;
          mix_nxt   = mix_start;
          inner_nxt = 1'b0;
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        mul_a     = MUL_A_W'(mix_r);
        mul_b     = $signed(MUL_B_W'(cfg.full_speed));
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        neg_nxt   = mul_p[MUL_P_W-1];
        m_nxt     = prod_mag[MAG_W-1:0];
        mul_a     = $signed(MUL_A_W'(prod_mag[MAG_W-1:0]));
        mul_b     = $signed(RECIP_B);
        state_nxt = ST_Q0;
      end
      ST_Q0: begin
        q_nxt     = Q_W'(mul_p[DIV_SHIFT +: Q0_W]);
        mul_a     = $signed(MUL_A_W'(mul_p[DIV_SHIFT +: Q0_W]));
        mul_b     = $signed(STICK_FULL_B);
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        // The reciprocal quotient is low by at most one.
        if (rem >= MAG_W'(STICK_FULL)) begin
          q_nxt = q_r + Q_W'(1);
        end
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        err_nxt   = sat16(SUM_W'(target) - SUM_W'(item_r.measured_speed));
        mul_a     = MUL_A_W'(err_nxt);
        mul_b     = $signed(MUL_B_W'(cfg.speed_ki));
        state_nxt = ST_INT;
      end
      ST_INT: begin
        if (inner_r) begin
          cint_nxt[item_r.wheel] = iclamp[CINT_W-1:0];
        end else begin
          sint_nxt[item_r.wheel] = iclamp[SINT_W-1:0];
        end
        mul_a     = MUL_A_W'(err_r);
        mul_b     = $signed(MUL_B_W'(kp_sel));
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!inner_r) begin
          ctgt_nxt  = pi_out16;
          err_nxt   = sat16(SUM_W'(pi_out16) - SUM_W'(item_r.measured_current));
          inner_nxt = 1'b1;
          mul_a     = MUL_A_W'(err_nxt);
          mul_b     = $signed(MUL_B_W'(cfg.current_ki));
          state_nxt = ST_INT;
        end else begin
          // Hold the product steady until the result is taken.
          mul_a = MUL_A_W'(err_r);
          mul_b = $signed(MUL_B_W'(kp_sel));
          if (res_take) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and integrators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      inner_r <= 1'b0;
      for (int i = 0; i < WHEELS; i++) begin
        sint_r[i] <= '0;
        cint_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      inner_r <= inner_nxt;
      sint_r  <= sint_nxt;
      cint_r  <= cint_nxt;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    mix_r  <= mix_nxt;
    m_r    <= m_nxt;
    neg_r  <= neg_nxt;
    q_r    <= q_nxt;
    err_r  <= err_nxt;
    ctgt_r <= ctgt_nxt;
  end

  assign idle               = (state_r == ST_IDLE);
  assign res_valid          = (state_r == ST_OUT) && inner_r;
  assign res.wheel_out      = item_r.wheel;
  assign res.current_target = ctgt_r;
  assign res.drive_value    = pi_out16;

endmodule
